### rtl/spss_pkg.sv
package spss_pkg;

  // Mode request codes carried by each poll word.
  localparam logic [1:0] REQ_KEEP = 2'd0;
  localparam logic [1:0] REQ_IDLE = 2'd1;
  localparam logic [1:0] REQ_FEED = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_READ_INTERVAL = 2'd0;
  localparam logic [1:0] REG_SETTLE_TIME   = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [31:0] READ_INTERVAL_RESET = 32'd30000;
  localparam logic [15:0] SETTLE_TIME_RESET   = 16'd300;

  // Operating mode.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'b01,
    MODE_FEED = 2'b10
  } mode_t;

  // Measurement phase. Idle mode uses all three, feeding mode the first two.
  typedef enum logic [2:0] {
    PH_WAIT   = 3'b001,
    PH_SETTLE = 3'b010,
    PH_HOLD   = 3'b100
  } phase_t;

endpackage

### rtl/sensor_power_sample_sequencer.sv
// Sensor power sequencer and sampler.
// The input channel (in_valid/in_ready) carries one poll word per transfer:
// a mode request, the current millisecond time and the converter sample.
// The output channel (out_valid/out_ready) returns exactly one result word
// per poll: the supply enable level, the most recently latched sample and a
// flag that marks a poll which latched a new sample.
// The result is registered: a poll accepted in one cycle has its result on
// the output in the next. Throughput is one poll per cycle while results
// are taken; the only loop is the sequencer state, updated once per poll.
// When the receiver stalls, the result word is held in the output register
// and in_ready drops until it is taken; the next poll is accepted in the same
// cycle in which the waiting result leaves.
// The configuration port (cfg_write, cfg_index, cfg_data) writes the read
// interval (index 0) or the settle time (index 1); other indexes are ignored.
// Writes belong to periods in which no poll is in flight.
// Synchronous reset empties the output register, restores both registers to
// their defaults, selects idle mode with the supply on and arms the first
// measurement.
module sensor_power_sample_sequencer #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             mode_request,
  input  logic [31:0]            now_ms,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   sensor_power,
  output logic [SAMPLE_BITS-1:0] moisture_value,
  output logic                   sample_taken,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  // Configuration registers.
  logic [31:0] read_interval;
  logic [15:0] settle_time;

  // Sequencer state.
  spss_pkg::phase_t         phase, phase_next;
  spss_pkg::mode_t          active_mode, mode_next;
  logic                     first_poll, first_poll_next;
  logic [31:0]              last_read_time, last_read_time_next;
  logic [31:0]              phase_entry_time, phase_entry_time_next;
  logic [SAMPLE_BITS-1:0]   held_sample, held_sample_next;
  logic                     power_level, power_level_next;
  logic                     taken;

  spss_pkg::phase_t         phase_eff;
  logic                     accept;
  logic                     interval_due;
  logic                     settle_done;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_interval <= spss_pkg::READ_INTERVAL_RESET;
      settle_time   <= spss_pkg::SETTLE_TIME_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spss_pkg::REG_READ_INTERVAL: read_interval <= cfg_data;
        spss_pkg::REG_SETTLE_TIME:   settle_time   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // A request for a different mode switches to it and restarts the phase.
  always_comb begin
    mode_next = active_mode;
    phase_eff = phase;
    if (mode_request == spss_pkg::REQ_IDLE && active_mode != spss_pkg::MODE_IDLE) begin
      mode_next = spss_pkg::MODE_IDLE;
      phase_eff = spss_pkg::PH_WAIT;
    end else if (mode_request == spss_pkg::REQ_FEED &&
                 active_mode != spss_pkg::MODE_FEED) begin
      mode_next = spss_pkg::MODE_FEED;
      phase_eff = spss_pkg::PH_WAIT;
    end
  end

  // Elapsed-time compares, modulo 2^32.
  assign interval_due = first_poll || ((now_ms - last_read_time) >= read_interval);
  assign settle_done  = (now_ms - phase_entry_time) >= {16'd0, settle_time};

  // Per-poll phase step.
  always_comb begin
    phase_next            = phase_eff;
    first_poll_next       = first_poll;
    last_read_time_next   = last_read_time;
    phase_entry_time_next = phase_entry_time;
    held_sample_next      = held_sample;
    power_level_next      = power_level;
    taken                 = 1'b0;
    if (mode_next == spss_pkg::MODE_IDLE) begin
      unique case (phase_eff)
        spss_pkg::PH_WAIT: begin
          if (interval_due) begin
            power_level_next      = 1'b1;
            phase_entry_time_next = now_ms;
            phase_next            = spss_pkg::PH_SETTLE;
            first_poll_next       = 1'b0;
          end else begin
            power_level_next = 1'b0;
          end
        end
        spss_pkg::PH_SETTLE: begin
          if (settle_done) begin
            held_sample_next      = adc_sample;
            taken                 = 1'b1;
            phase_entry_time_next = now_ms;
            phase_next            = spss_pkg::PH_HOLD;
          end
        end
        spss_pkg::PH_HOLD: begin
          if (settle_done) begin
            power_level_next    = 1'b0;
            last_read_time_next = now_ms;
            phase_next          = spss_pkg::PH_WAIT;
          end
        end
        default: ;
      endcase
    end else begin
      unique case (phase_eff)
        spss_pkg::PH_WAIT: begin
          power_level_next = 1'b1;
          phase_next       = spss_pkg::PH_SETTLE;
        end
        spss_pkg::PH_SETTLE: begin
          held_sample_next = adc_sample;
          taken            = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // State update on every accepted poll.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= spss_pkg::PH_WAIT;
      active_mode      <= spss_pkg::MODE_IDLE;
      first_poll       <= 1'b1;
      last_read_time   <= '0;
      phase_entry_time <= '0;
      held_sample      <= '0;
      power_level      <= 1'b1;
    end else if (accept) begin
      phase            <= phase_next;
      active_mode      <= mode_next;
      first_poll       <= first_poll_next;
      last_read_time   <= last_read_time_next;
      phase_entry_time <= phase_entry_time_next;
      held_sample      <= held_sample_next;
      power_level      <= power_level_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      sensor_power   <= power_level_next;
      moisture_value <= held_sample_next;
      sample_taken   <= taken;
    end
  end

endmodule

### rtl/sensor_power_sample_sequencer_checker.sv
module sensor_power_sample_sequencer_checker #(
  parameter int SAMPLE_BITS = 10
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   sensor_power,
  input logic [SAMPLE_BITS-1:0] moisture_value,
  input logic                   sample_taken
);

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(sensor_power) && $stable(moisture_value) && $stable(sample_taken))
    else $error("result word changed while stalled");

  // Every accepted poll yields a result word in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted poll produced no result word");

  // No new poll is taken while a result word waits.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("poll accepted over a waiting result word");

  // A sample is only ever latched with the supply on.
  a_sample_powered: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_taken |-> sensor_power)
    else $error("sample latched with the supply off");

endmodule

bind sensor_power_sample_sequencer sensor_power_sample_sequencer_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .sensor_power(sensor_power),
  .moisture_value(moisture_value),
  .sample_taken(sample_taken)
);
